FILE: rtl/utf8_punctuation_to_ascii_assert.svh
// Assertion macros used by the transliterator back end.
// Needs nothing but the including module's own signals.
`ifndef UTF8_PUNCTUATION_TO_ASCII_ASSERT_SVH
`define UTF8_PUNCTUATION_TO_ASCII_ASSERT_SVH

// Condition holds on the same edge as the trigger.
`define U2A_ASSERT_SAME(label, clk, rstn, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (trig) |-> (cond)) \
        else $error(msg);

// Condition holds on the edge after the trigger.
`define U2A_ASSERT_NEXT(label, clk, rstn, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (trig) |=> (cond)) \
        else $error(msg);

`endif

FILE: rtl/u2a_pkg.sv
// Shared types and byte codes of the UTF-8 punctuation transliterator.
// No dependencies.
`default_nettype none

package u2a_pkg;

    localparam int unsigned CFG_W   = 13;
    localparam int unsigned QDEPTH  = 3;
    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(256);

    localparam logic [7:0] BYTE_NUL      = 8'h00;
    localparam logic [7:0] BYTE_CONT     = 8'h80;
    localparam logic [7:0] BYTE_LEAD2    = 8'hC0;
    localparam logic [7:0] BYTE_LEAD3    = 8'hE0;
    localparam logic [7:0] BYTE_E2       = 8'hE2;
    localparam logic [7:0] BYTE_LEAD4    = 8'hF0;
    localparam logic [7:0] BYTE_EN_DASH  = 8'h93;
    localparam logic [7:0] BYTE_EM_DASH  = 8'h94;
    localparam logic [7:0] BYTE_LSQUO    = 8'h98;
    localparam logic [7:0] BYTE_RSQUO    = 8'h99;
    localparam logic [7:0] BYTE_LDQUO    = 8'h9C;
    localparam logic [7:0] BYTE_RDQUO    = 8'h9D;
    localparam logic [7:0] BYTE_ELLIPSIS = 8'hA6;

    localparam logic [7:0] ASCII_DASH  = 8'h2D;
    localparam logic [7:0] ASCII_APOS  = 8'h27;
    localparam logic [7:0] ASCII_QUOTE = 8'h22;
    localparam logic [7:0] ASCII_DOT   = 8'h2E;

    // One decoded operation for the output side.
    typedef struct packed {
        logic [7:0] ch;
        logic       valid;
        logic       dbl;
        logic       last;
    } u2a_op_t;

endpackage

`default_nettype wire

FILE: rtl/u2a_front.sv
// Front end: accepts input bytes, tracks the UTF-8 decode state and the
// character count, and pushes decoded operations. Depends on u2a_pkg.
`default_nettype none

module u2a_front #(
    parameter int unsigned MAX_CAPACITY = 4096
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     cfg_we,
    input  wire logic [u2a_pkg::CFG_W-1:0] cfg_wdata,
    input  wire logic                     in_fire,
    input  wire logic [7:0]               in_byte,
    input  wire logic                     in_last,
    output logic                          push,
    output u2a_pkg::u2a_op_t              push_op
);
    import u2a_pkg::*;

    localparam int unsigned CAP_BITS = $clog2(MAX_CAPACITY + 1);
    localparam int unsigned CW = (CAP_BITS > CFG_W) ? CAP_BITS : CFG_W;

    typedef enum logic [1:0] {
        PRE_IDLE,
        PRE_E2,
        PRE_E280
    } prefix_t;

    prefix_t            prefix_reg, prefix_next;
    logic [1:0]         skip_reg, skip_next;
    logic [CW-1:0]      count_reg, count_next;
    logic               full_reg, full_next;
    logic [CFG_W-1:0]   max_len_reg;

    logic [CW-1:0]      cfg_ext, cap, limit;
    logic               have;
    logic               dbl;
    logic [7:0]         ch;

    always_comb begin
        cfg_ext = CW'(max_len_reg);
        if (cfg_ext == '0) begin
            cap = CW'(1);
        end else if (cfg_ext > CW'(MAX_CAPACITY)) begin
            cap = CW'(MAX_CAPACITY);
        end else begin
            cap = cfg_ext;
        end
        limit = cap - CW'(1);
    end

    always_comb begin
        prefix_next = prefix_reg;
        skip_next   = skip_reg;
        count_next  = count_reg;
        full_next   = full_reg;
        have        = 1'b0;
        dbl         = 1'b0;
        ch          = 8'h00;
        if (full_reg) begin
            full_next = 1'b1;
        end else if (skip_reg != 2'd0) begin
            skip_next = skip_reg - 2'd1;
        end else if (prefix_reg == PRE_E2) begin
            if (in_byte == BYTE_CONT) begin
                prefix_next = PRE_E280;
            end else begin
                prefix_next = PRE_IDLE;
                skip_next   = 2'd1;
            end
        end else if (prefix_reg == PRE_E280) begin
            prefix_next = PRE_IDLE;
            if (in_byte == BYTE_EN_DASH || in_byte == BYTE_EM_DASH) begin
                ch = ASCII_DASH;
                have = 1'b1;
            end else if (in_byte == BYTE_LSQUO || in_byte == BYTE_RSQUO) begin
                ch = ASCII_APOS;
                have = 1'b1;
            end else if (in_byte == BYTE_LDQUO || in_byte == BYTE_RDQUO) begin
                ch = ASCII_QUOTE;
                have = 1'b1;
            end else if (in_byte == BYTE_ELLIPSIS &&
                         ({1'b0, count_reg} + (CW+1)'(2)) <= {1'b0, limit}) begin
                ch = ASCII_DOT;
                have = 1'b1;
                dbl = 1'b1;
            end
            if (dbl) begin
                count_next = count_reg + CW'(2);
            end else if (have) begin
                count_next = count_reg + CW'(1);
            end
        end else if (count_reg >= limit || in_byte == BYTE_NUL) begin
            full_next = 1'b1;
        end else if (in_byte < BYTE_CONT) begin
            ch = in_byte;
            have = 1'b1;
            count_next = count_reg + CW'(1);
        end else if (in_byte == BYTE_E2) begin
            prefix_next = PRE_E2;
        end else if (in_byte >= BYTE_LEAD4) begin
            skip_next = 2'd3;
        end else if (in_byte >= BYTE_LEAD3) begin
            skip_next = 2'd2;
        end else if (in_byte >= BYTE_LEAD2) begin
            skip_next = 2'd1;
        end
        if (in_last) begin
            prefix_next = PRE_IDLE;
            skip_next   = 2'd0;
            count_next  = '0;
            full_next   = 1'b0;
        end
    end

    assign push          = in_fire && (have || in_last);
    assign push_op.ch    = ch;
    assign push_op.valid = have;
    assign push_op.dbl   = dbl;
    assign push_op.last  = in_last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prefix_reg  <= PRE_IDLE;
            skip_reg    <= 2'd0;
            count_reg   <= '0;
            full_reg    <= 1'b0;
            max_len_reg <= CFG_RESET;
        end else begin
            if (in_fire) begin
                prefix_reg <= prefix_next;
                skip_reg   <= skip_next;
                count_reg  <= count_next;
                full_reg   <= full_next;
            end
            if (cfg_we) begin
                max_len_reg <= cfg_wdata;
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/u2a_queue.sv
// Short queue of decoded operations between front and back end.
// Depends on u2a_pkg.
`default_nettype none

module u2a_queue (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire u2a_pkg::u2a_op_t push_op,
    output logic                  full,
    input  wire logic             pop,
    output logic                  head_valid,
    output u2a_pkg::u2a_op_t      head_op
);
    import u2a_pkg::*;

    localparam int unsigned PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int unsigned NW = $clog2(QDEPTH + 1);

    u2a_op_t        mem_reg [QDEPTH];
    logic [PW-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [NW-1:0]  count_reg;

    assign full       = (count_reg == NW'(QDEPTH));
    assign head_valid = (count_reg != '0);
    assign head_op    = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(QDEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(QDEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + NW'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - NW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/u2a_back.sv
// Back end: turns queued operations into output words, splitting an
// ellipsis into two dots. Depends on u2a_pkg and the assertion macros.
`default_nettype none
`include "utf8_punctuation_to_ascii_assert.svh"

module u2a_back (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             head_valid,
    input  wire u2a_pkg::u2a_op_t head_op,
    output logic                  pop,
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output logic [7:0]            m_tdata,
    output logic [1:0]            m_tuser,
    output logic                  m_tlast
);
    import u2a_pkg::*;

    logic       tvalid_reg;
    logic [7:0] tdata_reg;
    logic [1:0] tuser_reg;
    logic       tlast_reg;
    logic       phase_reg;
    logic       load;
    logic       final_beat;

    assign load       = head_valid && (!tvalid_reg || m_tready);
    assign final_beat = !head_op.dbl || phase_reg;
    assign pop        = load && final_beat;

    assign m_tvalid = tvalid_reg;
    assign m_tdata  = tdata_reg;
    assign m_tuser  = tuser_reg;
    assign m_tlast  = tlast_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tvalid_reg <= 1'b0;
            phase_reg  <= 1'b0;
        end else begin
            if (load) begin
                tvalid_reg <= 1'b1;
                phase_reg  <= !final_beat;
            end else if (m_tready) begin
                tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            tdata_reg <= head_op.ch;
            tuser_reg <= {final_beat, head_op.valid};
            tlast_reg <= head_op.last && final_beat;
        end
    end

    `U2A_ASSERT_SAME(a_phase_on_ellipsis, aclk, aresetn, phase_reg, head_valid && head_op.dbl, "second dot pending without an ellipsis at the queue head")
    `U2A_ASSERT_SAME(a_mid_run_is_dot, aclk, aresetn, tvalid_reg && !tuser_reg[1], tdata_reg == ASCII_DOT && tuser_reg[0] && !tlast_reg, "word inside a run is not a first dot")
    `U2A_ASSERT_SAME(a_end_closes_run, aclk, aresetn, tvalid_reg && tlast_reg, tuser_reg[1], "message end on a word that does not close its run")
    `U2A_ASSERT_NEXT(a_first_dot_follows, aclk, aresetn, load && !final_beat, phase_reg && tvalid_reg, "first dot not followed by a pending second dot")

endmodule

`default_nettype wire

FILE: rtl/utf8_punctuation_to_ascii.sv
// Path: an accepted byte is decoded combinationally and written into the operation queue;
// the output register is then loaded from the queue head and drives m_tvalid.
// Throughput: one byte per cycle while the operation queue is not full; an ellipsis
// yields two dots, absorbed by the three-entry queue between decoder and output stage.
// Reset: synchronous active-low aresetn clears decode state and sets capacity to 256.
`default_nettype none

module utf8_punctuation_to_ascii #(
    parameter int unsigned MAX_CAPACITY = 4096
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      cfg_we,
    input  wire logic [u2a_pkg::CFG_W-1:0] cfg_wdata,
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    input  wire logic [7:0]                s_tdata,   // [7:0] in_byte
    input  wire logic                      s_tlast,
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    output logic [7:0]                     m_tdata,   // [7:0] out_char
    output logic [1:0]                     m_tuser,   // [0] char_valid, [1] run_last
    output logic                           m_tlast
);
    import u2a_pkg::*;

    logic    q_full;
    logic    push;
    u2a_op_t push_op;
    logic    pop;
    logic    head_valid;
    u2a_op_t head_op;

    assign s_tready = !q_full;

    u2a_front #(
        .MAX_CAPACITY(MAX_CAPACITY)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_fire   (s_tvalid && s_tready),
        .in_byte   (s_tdata),
        .in_last   (s_tlast),
        .push      (push),
        .push_op   (push_op)
    );

    u2a_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_op    (push_op),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_op    (head_op)
    );

    u2a_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_op    (head_op),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule

`default_nettype wire
